// File: hdl/swim_packet_framer_defines.svh
// -----------------------------------------------------------------------------
// swim_packet_framer assertion macros
// Shared property shorthands for the framer checker.
// -----------------------------------------------------------------------------
`ifndef SWIM_PACKET_FRAMER_DEFINES_SVH
`define SWIM_PACKET_FRAMER_DEFINES_SVH

// same-cycle implication, gated by reset
`define SPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated by reset
`define SPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/spf_pkg.sv
// -----------------------------------------------------------------------------
// spf_pkg
// Types, codes and constants of the single-wire link packet framer.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

  localparam int unsigned SPEED_W   = 23;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT = 2'd1;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 23'd363000;
  localparam logic [SPEED_W-1:0] FAST_HZ     = 23'd700000;

  localparam logic [7:0] CNT_SHORT     = 8'd2;
  localparam logic [7:0] CNT_FAST_LONG = 8'd8;
  localparam logic [7:0] CNT_SLOW_LONG = 8'd20;
  localparam logic [7:0] ENTRY_LOW     = 8'd160;
  localparam logic [7:0] ENTRY_HIGH    = 8'd8;

  localparam logic [3:0] BITS_SHORT = 4'd3;
  localparam logic [3:0] BITS_BYTE  = 4'd8;

  typedef enum logic [1:0] {
    FN_SEND   = 2'd0,
    FN_RECV   = 2'd1,
    FN_SAMPLE = 2'd2,
    FN_ENTRY  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_TOKEN     = 2'd0,
    KIND_SEND_DONE = 2'd1,
    KIND_RECV_DONE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_NOT_SEL    = 3'd1,
    STS_BAD_COUNT  = 3'd2,
    STS_NO_ACK     = 3'd3,
    STS_BAD_HDR    = 3'd4,
    STS_PARITY     = 3'd5,
    STS_UNEXPECTED = 3'd6
  } status_t;

  // where a pulse token takes its bit from
  typedef enum logic [2:0] {
    TOK_ZERO  = 3'd0,
    TOK_ONE   = 3'd1,
    TOK_DATA  = 3'd2,
    TOK_PAR   = 3'd3,
    TOK_ENTRY = 3'd4
  } tok_src_t;

  // controller -> datapath
  typedef struct packed {
    logic     emit;
    logic     emit_token;
    tok_src_t tok_src;
    kind_t    kind;
    status_t  status;
    logic     use_byte;
    logic     last;
    logic     tx_load;
    logic     tx_shift;
    logic     rx_clear;
    logic     rx_shift;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic selected;
    logic bad_count;
    logic tx_last_bit;
    logic rx_last_bit;
    logic rx_par_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/spf_if.sv
// -----------------------------------------------------------------------------
// spf_if
// Request, result and register-write channels of the packet framer.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_value;
  logic [3:0] bit_count;
  logic       sample;

  modport source (output valid, func, data_value, bit_count, sample, input ready);
  modport sink   (input valid, func, data_value, bit_count, sample, output ready);
endinterface

interface spf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] low_count;
  logic [7:0] high_count;
  logic [2:0] status;
  logic [7:0] data_out;
  logic       last;

  modport source (output valid, kind, low_count, high_count, status, data_out, last,
                  input ready);
  modport sink   (input valid, kind, low_count, high_count, status, data_out, last,
                  output ready);
endinterface

interface spf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [22:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// File: hdl/spf_ctrl.sv
// -----------------------------------------------------------------------------
// spf_ctrl
// Request decoder, token sequencer and link phase tracking.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spf_ctrl
  import spf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] in_func,
  input  logic      in_sample,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DATA   = 4'b0010,
    ST_PAR    = 4'b0100,
    ST_RXBYTE = 4'b1000
  } seq_state_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_ACK  = 5'b00010,
    PH_HDR  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_PAR  = 5'b10000
  } phase_t;

  seq_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       accept;

  function automatic ctrl_cmd_t fin_cmd(kind_t k, status_t s);
    ctrl_cmd_t c;
    c        = '0;
    c.emit   = 1'b1;
    c.kind   = k;
    c.status = s;
    c.last   = 1'b1;
    return c;
  endfunction

  function automatic ctrl_cmd_t tok_cmd(tok_src_t src, logic l);
    ctrl_cmd_t c;
    c            = '0;
    c.emit       = 1'b1;
    c.emit_token = 1'b1;
    c.tok_src    = src;
    c.kind       = KIND_TOKEN;
    c.status     = STS_OK;
    c.last       = l;
    return c;
  endfunction

  assign in_ready = (state_r == ST_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_func))
            FN_SEND: begin
              phase_nxt = PH_IDLE;
              if (stat.bad_count) begin
                cmd = fin_cmd(KIND_SEND_DONE, STS_BAD_COUNT);
              end else if (!stat.selected) begin
                cmd = fin_cmd(KIND_SEND_DONE, STS_NOT_SEL);
              end else begin
                cmd         = tok_cmd(TOK_ZERO, 1'b0);
                cmd.tx_load = 1'b1;
                phase_nxt   = PH_ACK;
                state_nxt   = ST_DATA;
              end
            end
            FN_RECV: begin
              if (!stat.selected) begin
                cmd       = fin_cmd(KIND_RECV_DONE, STS_NOT_SEL);
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_HDR;
              end
            end
            FN_ENTRY: begin
              phase_nxt = PH_IDLE;
              if (!stat.selected) begin
                cmd = fin_cmd(KIND_SEND_DONE, STS_NOT_SEL);
              end else begin
                cmd = tok_cmd(TOK_ENTRY, 1'b1);
              end
            end
            FN_SAMPLE: begin
              unique case (phase_r)
                PH_IDLE: begin
                  cmd = fin_cmd(KIND_RECV_DONE, STS_UNEXPECTED);
                end
                PH_ACK: begin
                  phase_nxt = PH_IDLE;
                  if (!stat.selected) begin
                    cmd = fin_cmd(KIND_SEND_DONE, STS_NOT_SEL);
                  end else if (in_sample) begin
                    cmd = fin_cmd(KIND_SEND_DONE, STS_OK);
                  end else begin
                    cmd = fin_cmd(KIND_SEND_DONE, STS_NO_ACK);
                  end
                end
                PH_HDR: begin
                  if (!stat.selected) begin
                    cmd       = fin_cmd(KIND_RECV_DONE, STS_NOT_SEL);
                    phase_nxt = PH_IDLE;
                  end else if (in_sample) begin
                    cmd       = fin_cmd(KIND_RECV_DONE, STS_BAD_HDR);
                    phase_nxt = PH_IDLE;
                  end else begin
                    cmd.rx_clear = 1'b1;
                    phase_nxt    = PH_DATA;
                  end
                end
                PH_DATA: begin
                  if (!stat.selected) begin
                    cmd       = fin_cmd(KIND_RECV_DONE, STS_NOT_SEL);
                    phase_nxt = PH_IDLE;
                  end else begin
                    cmd.rx_shift = 1'b1;
                    if (stat.rx_last_bit) begin
                      phase_nxt = PH_PAR;
                    end
                  end
                end
                PH_PAR: begin
                  phase_nxt = PH_IDLE;
                  if (!stat.selected) begin
                    cmd = fin_cmd(KIND_RECV_DONE, STS_NOT_SEL);
                  end else if (!stat.rx_par_ok) begin
                    cmd = fin_cmd(KIND_RECV_DONE, STS_PARITY);
                  end else begin
                    // ack token now, byte on the next free slot
                    cmd       = tok_cmd(TOK_ONE, 1'b0);
                    state_nxt = ST_RXBYTE;
                  end
                end
                default: begin
                  phase_nxt = PH_IDLE;
                end
              endcase
            end
          endcase
        end
      end
      ST_DATA: begin
        if (stat.out_free) begin
          cmd          = tok_cmd(TOK_DATA, 1'b0);
          cmd.tx_shift = 1'b1;
          if (stat.tx_last_bit) begin
            state_nxt = ST_PAR;
          end
        end
      end
      ST_PAR: begin
        if (stat.out_free) begin
          cmd       = tok_cmd(TOK_PAR, 1'b1);
          state_nxt = ST_IDLE;
        end
      end
      ST_RXBYTE: begin
        if (stat.out_free) begin
          cmd          = fin_cmd(KIND_RECV_DONE, STS_OK);
          cmd.use_byte = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/spf_dp.sv
// -----------------------------------------------------------------------------
// spf_dp
// Link registers, transmit/receive shifters, token counts and result register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spf_dp
  import spf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPEED_W-1:0]   cfg_wdata,
  // request payload
  input  logic [7:0]           in_data_value,
  input  logic [3:0]           in_bit_count,
  input  logic                 in_sample,
  // control
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_low_count,
  output logic [7:0]           out_high_count,
  output logic [2:0]           out_status,
  output logic [7:0]           out_data_out,
  output logic                 out_last
);

  logic [SPEED_W-1:0] speed_r;
  logic               sel_r;

  logic [7:0] tx_sh_r, tx_sh_nxt;
  logic [3:0] tx_cnt_r;
  logic       tx_par_r;

  logic [7:0] rx_byte_r;
  logic [2:0] rx_idx_r;
  logic       rx_par_r;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] kind_r;
  logic [7:0] low_r, high_r, data_r;
  logic [2:0] status_r;
  logic       last_r;

  logic       fast;
  logic [7:0] long_cnt;
  logic       tok_bit;
  logic [7:0] tok_low, tok_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RESET;
      sel_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPEED:  speed_r <= cfg_wdata;
        REG_SELECT: sel_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign fast     = (speed_r >= FAST_HZ);
  assign long_cnt = fast ? CNT_FAST_LONG : CNT_SLOW_LONG;

  // left-align the used bits so the MSB always leaves from bit 7
  assign tx_sh_nxt = (in_bit_count == BITS_SHORT) ? {in_data_value[2:0], 5'b0}
                                                   : in_data_value;

  always_ff @(posedge clk) begin
    if (cmd.tx_load) begin
      tx_sh_r  <= tx_sh_nxt;
      tx_cnt_r <= in_bit_count;
      tx_par_r <= 1'b0;
    end else if (cmd.tx_shift) begin
      tx_sh_r  <= {tx_sh_r[6:0], 1'b0};
      tx_cnt_r <= tx_cnt_r - 4'd1;
      tx_par_r <= tx_par_r ^ tx_sh_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_clear) begin
      rx_byte_r <= '0;
      rx_idx_r  <= '0;
      rx_par_r  <= 1'b0;
    end else if (cmd.rx_shift) begin
      rx_byte_r <= {rx_byte_r[6:0], in_sample};
      rx_idx_r  <= rx_idx_r + 3'd1;
      rx_par_r  <= rx_par_r ^ in_sample;
    end
  end

  always_comb begin
    case (cmd.tok_src)
      TOK_ONE:  tok_bit = 1'b1;
      TOK_DATA: tok_bit = tx_sh_r[7];
      TOK_PAR:  tok_bit = tx_par_r;
      default:  tok_bit = 1'b0;
    endcase
    if (cmd.tok_src == TOK_ENTRY) begin
      tok_low  = ENTRY_LOW;
      tok_high = ENTRY_HIGH;
    end else if (tok_bit) begin
      tok_low  = CNT_SHORT;
      tok_high = long_cnt;
    end else begin
      tok_low  = long_cnt;
      tok_high = CNT_SHORT;
    end
  end

  assign out_valid_nxt = cmd.emit | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r   <= cmd.kind;
      status_r <= cmd.status;
      last_r   <= cmd.last;
      low_r    <= cmd.emit_token ? tok_low  : 8'd0;
      high_r   <= cmd.emit_token ? tok_high : 8'd0;
      data_r   <= cmd.use_byte   ? rx_byte_r : 8'd0;
    end
  end

  assign stat.out_free    = ~out_valid_r | out_ready;
  assign stat.selected    = sel_r;
  assign stat.bad_count   = (in_bit_count != BITS_SHORT) && (in_bit_count != BITS_BYTE);
  assign stat.tx_last_bit = (tx_cnt_r == 4'd1);
  assign stat.rx_last_bit = (rx_idx_r == 3'(BITS_BYTE - 4'd1));
  assign stat.rx_par_ok   = (in_sample == rx_par_r);

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_low_count  = low_r;
  assign out_high_count = high_r;
  assign out_status     = status_r;
  assign out_data_out   = data_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

// File: hdl/swim_packet_framer.sv
// -----------------------------------------------------------------------------
// swim_packet_framer
// Packet engine for a single-wire debug link. A send request turns a 3- or
// 8-bit value into pulse tokens (drive-low and release loop counts): a zero
// header, the data bits MSB first, then even parity; short pulses at 700 kHz
// and above, long ones below. The next line sample is the acknowledge. A
// receive request is followed by line samples (header, 8 data bits, parity);
// a good byte is answered with an ACK token and then the byte itself. An entry
// request gives the long reset pulse. Results leave through one output
// register, one per cycle while the sink is ready: a send puts out its zero
// header token when it is accepted, then one token per data bit and one for
// parity; the parity sample that closes a good receive gives an ACK token,
// then the byte; a receive request and its header and data samples give no
// result unless they fail; every other request gives one. The token
// sequencer feeds that single output register; a new request is taken once
// the sequencer is back in idle and the output register is empty or being
// read. Register writes are taken in any cycle, no reset sweep is needed.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swim_packet_framer
  import spf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  spf_in_if.sink           in_ch,
  spf_out_if.source        out_ch,
  spf_cfg_if.sink          cfg_ch
);

  ctrl_cmd_t cmd;     // sequencer commands for this cycle
  dp_stat_t  stat;    // datapath flags back to the sequencer

  // Controller: decodes requests, tracks link phase (ack wait, header, data,
  // parity) and steps through token emission one result per free slot.
  spf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .in_sample (in_ch.sample),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: link registers, tx/rx shifters with parity, token count
  // selection and the output register that decouples the result sink.
  spf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_index      (cfg_ch.index),
    .cfg_wdata      (cfg_ch.wdata),
    .in_data_value  (in_ch.data_value),
    .in_bit_count   (in_ch.bit_count),
    .in_sample      (in_ch.sample),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_low_count  (out_ch.low_count),
    .out_high_count (out_ch.high_count),
    .out_status     (out_ch.status),
    .out_data_out   (out_ch.data_out),
    .out_last       (out_ch.last)
  );

endmodule

`default_nettype wire

// File: hdl/spf_checker.sv
// -----------------------------------------------------------------------------
// spf_checker
// Port-level checks of the packet framer, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "swim_packet_framer_defines.svh"

module spf_checker
  import spf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_low_count,
  input logic [7:0] out_high_count,
  input logic [2:0] out_status,
  input logic [7:0] out_data_out,
  input logic       out_last
);

  // stalled result holds
  `SPF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_low_count) && $stable(out_status) && $stable(out_data_out) && $stable(out_last), "stalled result changed")

  // mid-run results keep the request side closed
  `SPF_ASSERT_IMP(a_busy_mid_run, out_valid && !out_last, !in_ready, "request taken while a run is pending")

  // tokens carry both counts and no status or byte
  `SPF_ASSERT_IMP(a_token_shape, out_valid && out_kind == KIND_TOKEN, out_low_count != 8'd0 && out_high_count != 8'd0 && out_status == STS_OK && out_data_out == 8'd0, "malformed token")

  // finish reports end their run and carry no counts
  `SPF_ASSERT_IMP(a_done_shape, out_valid && out_kind != KIND_TOKEN, out_last && out_low_count == 8'd0 && out_high_count == 8'd0, "malformed finish report")

  // a byte only rides on a good receive
  `SPF_ASSERT_IMP(a_byte_only_rx_ok, out_valid && out_data_out != 8'd0, out_kind == KIND_RECV_DONE && out_status == STS_OK, "byte outside good receive")

endmodule

bind swim_packet_framer spf_checker u_spf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_low_count  (out_ch.low_count),
  .out_high_count (out_ch.high_count),
  .out_status     (out_ch.status),
  .out_data_out   (out_ch.data_out),
  .out_last       (out_ch.last)
);

`default_nettype wire
